[rtl/free_list_entry_allocator_assert.svh]
// Assertion macros used by the allocator datapath.
// Each use expects clk and arst_n in scope.
`ifndef FREE_LIST_ENTRY_ALLOCATOR_ASSERT_SVH
`define FREE_LIST_ENTRY_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define FLEA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FLEA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/fle_alloc_pkg.sv]
`timescale 1ns / 1ps

package fle_alloc_pkg;

	localparam int DEFAULT_POOL_SIZE = 256;
	localparam int MAX_ENTRIES = 256;
	localparam int LINK_W = 9;
	localparam int CMD_W = 3;
	localparam int ENT_W = 8;

	typedef logic [LINK_W-1:0] link_t;
	typedef logic [LINK_W-1:0] cnt_t;
	typedef logic [CMD_W-1:0] cmd_code_t;
	typedef logic [ENT_W-1:0] ent_t;

	localparam link_t NULL_LINK = link_t'(MAX_ENTRIES);

	// Command codes
	localparam cmd_code_t CMD_ALLOC_ONE = 3'd0;
	localparam cmd_code_t CMD_ALLOC_LIST = 3'd1;
	localparam cmd_code_t CMD_FREE_ONE = 3'd2;
	localparam cmd_code_t CMD_FREE_LIST = 3'd3;
	localparam cmd_code_t CMD_WRITE_LINK = 3'd4;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	// Datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE = 4'd0,
		OP_CLEAR = 4'd1,
		OP_LOAD = 4'd2,
		OP_STEP = 4'd3,
		OP_POP = 4'd4,
		OP_CUT = 4'd5,
		OP_PUSH = 4'd6,
		OP_SPLICE = 4'd7,
		OP_LINK = 4'd8,
		OP_REPORT = 4'd9
	} op_t;

	typedef struct packed {
		op_t op;
		status_t st;
	} ctrl_cmd_t;

	typedef struct packed {
		cmd_code_t cmd;
		logic no_free;
		logic all_free;
		logic head_bad;
		logic len_zero;
		logic len_over;
		logic ent_bad;
		logic tgt_bad;
		logic run_done;
		logic link_null;
		logic link_bad;
		logic walk_over;
		logic clr_last;
		logic out_free;
	} dp_stat_t;

	function automatic int entry_count(input int pool);
		return (pool < MAX_ENTRIES) ? pool : MAX_ENTRIES;
	endfunction

endpackage

[rtl/fle_alloc_ram.sv]
`timescale 1ns / 1ps

module fle_alloc_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/fle_alloc_ctrl.sv]
`timescale 1ns / 1ps

module fle_alloc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input fle_alloc_pkg::dp_stat_t stat,
	output fle_alloc_pkg::ctrl_cmd_t ctrl
);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE = 5'b00010,
		S_EXEC = 5'b00100,
		S_WALK_ALLOC = 5'b01000,
		S_WALK_FREE = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	logic fin;
	fle_alloc_pkg::op_t fin_op;
	fle_alloc_pkg::status_t fin_st;
	logic step;
	logic alloc_walk;
	logic free_walk;

	always_comb begin
		fin = 1'b0;
		fin_op = fle_alloc_pkg::OP_REPORT;
		fin_st = fle_alloc_pkg::ST_OK;
		alloc_walk = 1'b0;
		free_walk = 1'b0;
		if (state_q == S_EXEC) begin
			case (stat.cmd)
				fle_alloc_pkg::CMD_ALLOC_ONE: begin
					fin = 1'b1;
					if (stat.no_free || stat.head_bad) begin
						fin_st = fle_alloc_pkg::ST_EXHAUSTED;
					end else begin
						fin_op = fle_alloc_pkg::OP_POP;
					end
				end
				fle_alloc_pkg::CMD_ALLOC_LIST: begin
					if (stat.len_zero) begin
						fin = 1'b1;
					end else if (stat.len_over || stat.head_bad) begin
						fin = 1'b1;
						fin_st = fle_alloc_pkg::ST_EXHAUSTED;
					end else begin
						alloc_walk = 1'b1;
					end
				end
				fle_alloc_pkg::CMD_FREE_ONE: begin
					fin = 1'b1;
					if (stat.all_free || stat.ent_bad) begin
						fin_st = fle_alloc_pkg::ST_INVALID;
					end else begin
						fin_op = fle_alloc_pkg::OP_PUSH;
					end
				end
				fle_alloc_pkg::CMD_FREE_LIST: begin
					if (stat.all_free || stat.ent_bad) begin
						fin = 1'b1;
						fin_st = fle_alloc_pkg::ST_INVALID;
					end else begin
						free_walk = 1'b1;
					end
				end
				fle_alloc_pkg::CMD_WRITE_LINK: begin
					fin = 1'b1;
					if (stat.ent_bad || stat.tgt_bad) begin
						fin_st = fle_alloc_pkg::ST_INVALID;
					end else begin
						fin_op = fle_alloc_pkg::OP_LINK;
					end
				end
				default: begin
					fin = 1'b1;
				end
			endcase
		end
		if (state_q == S_WALK_ALLOC) begin
			alloc_walk = 1'b1;
		end
		if (state_q == S_WALK_FREE) begin
			free_walk = 1'b1;
		end
	end

	// Clear, load, finish; walks end at run or list end, stop on bad link/overrun
	always_comb begin
		step = 1'b0;
		state_d = state_q;
		ctrl.op = fle_alloc_pkg::OP_NONE;
		ctrl.st = fle_alloc_pkg::ST_OK;
		case (state_q)
			S_CLEAR: begin
				ctrl.op = fle_alloc_pkg::OP_CLEAR;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					ctrl.op = fle_alloc_pkg::OP_LOAD;
					state_d = S_EXEC;
				end
			end
			S_EXEC, S_WALK_ALLOC, S_WALK_FREE: begin
				if (alloc_walk) begin
					if (stat.run_done) begin
						ctrl.op = fle_alloc_pkg::OP_CUT;
					end else if (stat.link_bad) begin
						ctrl.op = fle_alloc_pkg::OP_REPORT;
						ctrl.st = fle_alloc_pkg::ST_EXHAUSTED;
					end else begin
						step = 1'b1;
						state_d = S_WALK_ALLOC;
					end
				end else if (free_walk) begin
					if (stat.link_null) begin
						ctrl.op = fle_alloc_pkg::OP_SPLICE;
					end else if (stat.walk_over || stat.link_bad) begin
						ctrl.op = fle_alloc_pkg::OP_REPORT;
						ctrl.st = fle_alloc_pkg::ST_INVALID;
					end else begin
						step = 1'b1;
						state_d = S_WALK_FREE;
					end
				end else if (fin) begin
					ctrl.op = fin_op;
					ctrl.st = fin_st;
				end
				if (step) begin
					ctrl.op = fle_alloc_pkg::OP_STEP;
				end else if (!stat.out_free) begin
					// hold until the result slot drains
					ctrl.op = fle_alloc_pkg::OP_NONE;
					ctrl.st = fle_alloc_pkg::ST_OK;
				end else begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

[rtl/fle_alloc_dp.sv]
`timescale 1ns / 1ps
`include "free_list_entry_allocator_assert.svh"

module fle_alloc_dp #(
	parameter int POOL_SIZE = fle_alloc_pkg::DEFAULT_POOL_SIZE
) (
	input logic clk,
	input logic arst_n,
	input fle_alloc_pkg::ctrl_cmd_t ctrl,
	output fle_alloc_pkg::dp_stat_t stat,
	input fle_alloc_pkg::cmd_code_t command,
	input fle_alloc_pkg::ent_t entry_index,
	input fle_alloc_pkg::cnt_t list_length,
	input fle_alloc_pkg::link_t link_target,
	output logic out_valid,
	input logic out_ready,
	output fle_alloc_pkg::link_t result_index,
	output fle_alloc_pkg::cnt_t free_count,
	output logic [1:0] status
);

	localparam int ENTRY_COUNT = fle_alloc_pkg::entry_count(POOL_SIZE);
	localparam int ADDR_W = $clog2(ENTRY_COUNT);
	localparam fle_alloc_pkg::link_t EC_L = fle_alloc_pkg::link_t'(ENTRY_COUNT);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRY_COUNT - 1);

	fle_alloc_pkg::cmd_code_t cmd_q;
	fle_alloc_pkg::ent_t ent_q;
	fle_alloc_pkg::cnt_t len_q;
	fle_alloc_pkg::link_t tgt_q;
	fle_alloc_pkg::link_t head_q;
	fle_alloc_pkg::link_t head_d;
	fle_alloc_pkg::cnt_t count_q;
	fle_alloc_pkg::cnt_t count_d;
	fle_alloc_pkg::cnt_t u_q;
	fle_alloc_pkg::cnt_t in_use;
	logic [ADDR_W-1:0] cur_q;
	logic [ADDR_W-1:0] clr_q;

	logic ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	fle_alloc_pkg::link_t ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	fle_alloc_pkg::link_t ram_rdata;

	logic out_valid_q;
	fle_alloc_pkg::link_t result_q;
	fle_alloc_pkg::cnt_t free_count_q;
	fle_alloc_pkg::status_t status_q;
	logic load_out;
	logic out_free;
	fle_alloc_pkg::link_t res_d;

	fle_alloc_ram #(
		.WIDTH(fle_alloc_pkg::LINK_W),
		.DEPTH(ENTRY_COUNT)
	) u_link_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Read address: first link of the operation on load, the link just read on a step
	always_comb begin
		case (ctrl.op)
			fle_alloc_pkg::OP_LOAD: begin
				if (command == fle_alloc_pkg::CMD_FREE_LIST) begin
					ram_raddr = entry_index[ADDR_W-1:0];
				end else begin
					ram_raddr = head_q[ADDR_W-1:0];
				end
			end
			fle_alloc_pkg::OP_STEP: ram_raddr = ram_rdata[ADDR_W-1:0];
			default: ram_raddr = cur_q;
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = fle_alloc_pkg::NULL_LINK;
		head_d = head_q;
		count_d = count_q;
		case (ctrl.op)
			fle_alloc_pkg::OP_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				if (clr_q != LAST_ADDR) begin
					ram_wdata = fle_alloc_pkg::link_t'(clr_q) + fle_alloc_pkg::link_t'(1);
				end
			end
			fle_alloc_pkg::OP_POP: begin
				ram_we = 1'b1;
				ram_waddr = head_q[ADDR_W-1:0];
				head_d = ram_rdata;
				count_d = count_q - fle_alloc_pkg::cnt_t'(1);
			end
			fle_alloc_pkg::OP_CUT: begin
				ram_we = 1'b1;
				head_d = ram_rdata;
				count_d = count_q - len_q;
			end
			fle_alloc_pkg::OP_PUSH: begin
				ram_we = 1'b1;
				ram_waddr = ent_q[ADDR_W-1:0];
				ram_wdata = head_q;
				head_d = fle_alloc_pkg::link_t'(ent_q);
				count_d = count_q + fle_alloc_pkg::cnt_t'(1);
			end
			fle_alloc_pkg::OP_SPLICE: begin
				ram_we = 1'b1;
				ram_wdata = head_q;
				head_d = fle_alloc_pkg::link_t'(ent_q);
				count_d = count_q + u_q;
			end
			fle_alloc_pkg::OP_LINK: begin
				ram_we = 1'b1;
				ram_waddr = ent_q[ADDR_W-1:0];
				ram_wdata = tgt_q;
			end
			default: begin
			end
		endcase
	end

	assign load_out = ctrl.op inside {fle_alloc_pkg::OP_POP, fle_alloc_pkg::OP_CUT,
		fle_alloc_pkg::OP_PUSH, fle_alloc_pkg::OP_SPLICE, fle_alloc_pkg::OP_LINK,
		fle_alloc_pkg::OP_REPORT};
	assign res_d = (ctrl.op == fle_alloc_pkg::OP_POP || ctrl.op == fle_alloc_pkg::OP_CUT) ?
		head_q : fle_alloc_pkg::NULL_LINK;
	assign out_free = !out_valid_q || out_ready;
	assign in_use = EC_L - count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= EC_L;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			head_q <= head_d;
			count_q <= count_d;
			if (ctrl.op == fle_alloc_pkg::OP_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == fle_alloc_pkg::OP_LOAD) begin
			cmd_q <= command;
			ent_q <= entry_index;
			len_q <= list_length;
			tgt_q <= link_target;
			u_q <= fle_alloc_pkg::cnt_t'(1);
			if (command == fle_alloc_pkg::CMD_FREE_LIST) begin
				cur_q <= entry_index[ADDR_W-1:0];
			end else begin
				cur_q <= head_q[ADDR_W-1:0];
			end
		end else if (ctrl.op == fle_alloc_pkg::OP_STEP) begin
			cur_q <= ram_rdata[ADDR_W-1:0];
			u_q <= u_q + fle_alloc_pkg::cnt_t'(1);
		end
		if (load_out) begin
			result_q <= res_d;
			free_count_q <= count_d;
			status_q <= ctrl.st;
		end
	end

	always_comb begin
		stat.cmd = cmd_q;
		stat.no_free = (count_q == '0);
		stat.all_free = (count_q >= EC_L);
		stat.head_bad = (head_q >= EC_L);
		stat.len_zero = (len_q == '0);
		stat.len_over = (len_q > count_q);
		stat.ent_bad = (fle_alloc_pkg::link_t'(ent_q) >= EC_L);
		stat.tgt_bad = (tgt_q != fle_alloc_pkg::NULL_LINK) && (tgt_q >= EC_L);
		stat.run_done = (u_q == len_q);
		stat.link_null = (ram_rdata == fle_alloc_pkg::NULL_LINK);
		stat.link_bad = (ram_rdata >= EC_L);
		stat.walk_over = (u_q >= in_use);
		stat.clr_last = (clr_q == LAST_ADDR);
		stat.out_free = out_free;
	end

	assign out_valid = out_valid_q;
	assign result_index = result_q;
	assign free_count = free_count_q;
	assign status = status_q;

	`FLEA_ASSERT_NOW(a_count_bound, 1'b1, count_q <= EC_L, "free count above pool size")
	`FLEA_ASSERT_NOW(a_no_overwrite, load_out, out_free, "result overwritten before taken")
	`FLEA_ASSERT_NOW(a_result_ok, load_out && (res_d != fle_alloc_pkg::NULL_LINK), ctrl.st == fle_alloc_pkg::ST_OK, "entry returned with error status")
	`FLEA_ASSERT_NEXT(a_clear_quiet, ctrl.op == fle_alloc_pkg::OP_CLEAR, (head_q == '0) && (count_q == EC_L), "free list moved during link clear")

endmodule

[rtl/free_list_entry_allocator.sv]
// Free-list entry allocator: hands out and takes back entries of a fixed pool
// of min(POOL_SIZE, 256) entries, with a link memory holding one next index per
// entry and 256 as the null link. Each input transaction carries one command
// (alloc one, alloc list, free one, free list, write link) and yields exactly one
// result transaction with the allocated index (or 256), the free count after the
// operation, and a status (ok, pool exhausted, invalid free or link write); a
// failing command changes nothing. Timing: after reset the link memory is
// initialized by a sweep of one entry per cycle, with in_ready low. Alloc one,
// free one, write link and the unknown codes finish in the state after accept,
// with at most one write of the link memory. Alloc list of N entries and free
// list of an L-entry client list read the link memory once per walked link,
// the registered read port feeding the next address. The block accepts the
// next transaction in the cycle after a result is registered, while that
// result may still wait for out_ready; it only holds an operation's finish
// while the output register is occupied.
`timescale 1ns / 1ps

module free_list_entry_allocator #(
	parameter int POOL_SIZE = fle_alloc_pkg::DEFAULT_POOL_SIZE
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input fle_alloc_pkg::cmd_code_t command,
	input fle_alloc_pkg::ent_t entry_index,
	input fle_alloc_pkg::cnt_t list_length,
	input fle_alloc_pkg::link_t link_target,
	output logic out_valid,
	input logic out_ready,
	output fle_alloc_pkg::link_t result_index,
	output fle_alloc_pkg::cnt_t free_count,
	output logic [1:0] status
);

	// Controller/datapath handshake: operation strobe down, decoded flags up
	fle_alloc_pkg::ctrl_cmd_t ctrl;
	fle_alloc_pkg::dp_stat_t stat;

	// Sequence each transaction: clear sweep, load, check, walk, finish
	fle_alloc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat(stat),
		.ctrl(ctrl)
	);

	// Hold the free list head and count, the link memory and the result register
	fle_alloc_dp #(
		.POOL_SIZE(POOL_SIZE)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.stat(stat),
		.command(command),
		.entry_index(entry_index),
		.list_length(list_length),
		.link_target(link_target),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_index(result_index),
		.free_count(free_count),
		.status(status)
	);

endmodule
